FILE: hdl/t4gb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// t4gb_pkg
// Shared types and constants of the tiled 4bpp glyph row blitter: request
// and result payloads, the queue entry between front and back, and the
// configuration register indexes.
// ----------------------------------------------------------------------------
package t4gb_pkg;

  // pixels in one row word, fixed by the 32-bit word of 4-bit pixels
  localparam int PIXELS_PER_ROW_WORD = 8;
  localparam int PIX_W               = 4;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HEIGHT = 1'd1;
  localparam logic [CFG_DATA_W-1:0] WINDOW_WIDTH_RESET  = 6'd30;
  localparam logic [CFG_DATA_W-1:0] WINDOW_HEIGHT_RESET = 6'd20;

  // queue between front and back, depth a power of two
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int OFF_W = 15;

  typedef struct packed {
    logic signed [15:0] glyph_left;
    logic signed [15:0] glyph_top;
    logic [3:0]         row_index;
    logic [3:0]         glyph_width;
    logic [31:0]        row_pixels;
  } in_item_t;

  typedef struct packed {
    logic [OFF_W-1:0] byte_offset;
    logic             high_nibble;
    logic [PIX_W-1:0] pixel_value;
    logic             last_write;
  } out_item_t;

  // one classified row: columns to write and the offset of the row in the buffer
  typedef struct packed {
    logic [PIXELS_PER_ROW_WORD-1:0] write_mask;
    logic [15:0]                    left;
    logic [31:0]                    pixels;
    logic [OFF_W-1:0]               row_base;
  } row_entry_t;

endpackage : t4gb_pkg
`default_nettype wire

FILE: hdl/tiled_4bpp_glyph_row_blitter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tiled_4bpp_glyph_row_blitter
// Turns glyph pixel rows into nibble writes for a 4bpp window buffer of
// 8x8 tiles.
// ----------------------------------------------------------------------------
// Each request is one glyph row of up to eight 4-bit pixels. The front
// clips it against the window and classifies it in the cycle it is taken;
// a two-entry queue then hands it to the back, which issues one nibble
// write per cycle while out_ready allows, through a registered output,
// last_write marking the final write of a row. A row gives one write per
// written pixel (up to eight); a row that writes nothing is absorbed by
// the front and produces no result. Requests keep flowing while writes
// wait on out_ready, until the queue fills. Window size registers may
// only be written while no row is in flight; sizes above MAX_WINDOW_TILES
// act as MAX_WINDOW_TILES and a size of zero clips all.
// ----------------------------------------------------------------------------
module tiled_4bpp_glyph_row_blitter #(
  parameter int MAX_WINDOW_TILES = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire t4gb_pkg::in_item_t                in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output t4gb_pkg::out_item_t                    out_data,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [t4gb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [t4gb_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic [t4gb_pkg::CFG_DATA_W-1:0] window_width_tiles;
  logic [t4gb_pkg::CFG_DATA_W-1:0] window_height_tiles;

  logic                   push;
  t4gb_pkg::row_entry_t   push_entry;
  logic                   q_full;
  logic                   pop;
  logic                   q_valid;
  t4gb_pkg::row_entry_t   q_entry;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_width_tiles  <= t4gb_pkg::WINDOW_WIDTH_RESET;
      window_height_tiles <= t4gb_pkg::WINDOW_HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        t4gb_pkg::REG_WINDOW_WIDTH:  window_width_tiles  <= cfg_data;
        t4gb_pkg::REG_WINDOW_HEIGHT: window_height_tiles <= cfg_data;
        default: ;
      endcase
    end
  end

  // classify
  t4gb_front #(
    .MAX_WINDOW_TILES (MAX_WINDOW_TILES)
  ) u_front (
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_data             (in_data),
    .window_width_tiles  (window_width_tiles),
    .window_height_tiles (window_height_tiles),
    .q_full              (q_full),
    .push                (push),
    .push_entry          (push_entry)
  );

  // decoupling queue
  t4gb_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .q_valid    (q_valid),
    .q_entry    (q_entry)
  );

  // issue writes
  t4gb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule : tiled_4bpp_glyph_row_blitter
`default_nettype wire

FILE: hdl/t4gb_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// t4gb_front
// Request side: clips the row vertically, builds the mask of columns that
// give a write, and works out the row's base offset in the tile buffer.
// ----------------------------------------------------------------------------
module t4gb_front #(
  parameter int MAX_WINDOW_TILES = 32
) (
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire t4gb_pkg::in_item_t                   in_data,
  input  wire logic [t4gb_pkg::CFG_DATA_W-1:0]      window_width_tiles,
  input  wire logic [t4gb_pkg::CFG_DATA_W-1:0]      window_height_tiles,
  input  wire logic                                 q_full,
  output logic                                      push,
  output t4gb_pkg::row_entry_t                      push_entry
);

  localparam int PW = $clog2(MAX_WINDOW_TILES + 1);
  localparam int NP = t4gb_pkg::PIXELS_PER_ROW_WORD;

  logic [PW-1:0]   pitch;
  logic [PW-1:0]   height;
  logic [PW+2:0]   win_w;
  logic [PW+2:0]   win_h;
  logic [16:0]     y;
  logic            y_ok;
  logic [PW-1:0]   y_tile;
  logic [2*PW-1:0] tile_row;
  logic [3:0]      cols;
  logic [16:0]     xs [NP];
  logic [NP-1:0]   mask;

  // clamp window size to the largest supported window
  always_comb begin
    pitch  = ({1'b0, window_width_tiles} > 7'(MAX_WINDOW_TILES)) ?
             PW'(MAX_WINDOW_TILES) : PW'(window_width_tiles);
    height = ({1'b0, window_height_tiles} > 7'(MAX_WINDOW_TILES)) ?
             PW'(MAX_WINDOW_TILES) : PW'(window_height_tiles);
    win_w  = {pitch, 3'b000};
    win_h  = {height, 3'b000};
  end

  // vertical clip and row base offset
  always_comb begin
    y        = {in_data.glyph_top[15], in_data.glyph_top} + 17'(in_data.row_index);
    y_ok     = !y[16] && (y[15:0] < 16'(win_h));
    y_tile   = y[PW+2:3];
    tile_row = (2*PW)'(y_tile) * (2*PW)'(pitch);
    cols     = (in_data.glyph_width > 4'(NP)) ? 4'(NP) : in_data.glyph_width;
  end

  // per column: in use, inside the window, not transparent
  always_comb begin
    for (int c = 0; c < NP; c++) begin
      xs[c]   = {in_data.glyph_left[15], in_data.glyph_left} + 17'(c);
      mask[c] = y_ok && (4'(c) < cols) && !xs[c][16] &&
                (xs[c][15:0] < 16'(win_w)) &&
                (in_data.row_pixels[c*t4gb_pkg::PIX_W +: t4gb_pkg::PIX_W] != '0);
    end
  end

  // rows with nothing to write are absorbed here
  assign in_ready = !q_full;
  assign push     = in_valid && in_ready && (mask != '0);

  always_comb begin
    push_entry.write_mask = mask;
    push_entry.left       = in_data.glyph_left;
    push_entry.pixels     = in_data.row_pixels;
    push_entry.row_base   = t4gb_pkg::OFF_W'({tile_row, 5'b00000}) +
                            t4gb_pkg::OFF_W'({y[2:0], 2'b00});
  end

endmodule : t4gb_front
`default_nettype wire

FILE: hdl/t4gb_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// t4gb_fifo
// Short register queue of classified rows between front and back, so that
// each side can stall on its own.
// ----------------------------------------------------------------------------
module t4gb_fifo (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire t4gb_pkg::row_entry_t  push_entry,
  output logic                       full,
  input  wire logic                  pop,
  output logic                       q_valid,
  output t4gb_pkg::row_entry_t       q_entry
);

  t4gb_pkg::row_entry_t              slots [t4gb_pkg::QUEUE_DEPTH];
  logic [t4gb_pkg::QPTR_W-1:0]       wr_ptr;
  logic [t4gb_pkg::QPTR_W-1:0]       rd_ptr;
  logic [t4gb_pkg::QCNT_W-1:0]       count;

  assign full    = (count == t4gb_pkg::QCNT_W'(t4gb_pkg::QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_entry = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) pop |-> q_valid)
    else $error("queue popped while empty");
  assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue pushed while full");

endmodule : t4gb_fifo
`default_nettype wire

FILE: hdl/t4gb_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// t4gb_back
// Write side: walks the column mask of the current row, one nibble write
// a cycle while the output is not stalled, into an output register.
// ----------------------------------------------------------------------------
module t4gb_back (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  q_valid,
  input  wire t4gb_pkg::row_entry_t  q_entry,
  output logic                       pop,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output t4gb_pkg::out_item_t        out_data
);

  localparam int NP = t4gb_pkg::PIXELS_PER_ROW_WORD;

  logic                          busy;
  logic [NP-1:0]                 mask;
  logic [15:0]                   left;
  logic [31:0]                   pixels;
  logic [t4gb_pkg::OFF_W-1:0]    row_base;

  logic                          emit;
  logic [NP-1:0]                 rest;
  logic [2:0]                    col;
  logic [15:0]                   x;
  t4gb_pkg::out_item_t           wr_next;

  // lowest pending column
  always_comb begin
    col = '0;
    for (int c = NP - 1; c >= 0; c--) begin
      if (mask[c]) col = 3'(c);
    end
    rest = mask & (mask - 1'b1);
  end

  // address and value of the write
  always_comb begin
    x                   = left + 16'(col);
    wr_next.byte_offset = row_base + t4gb_pkg::OFF_W'({x[12:3], 5'b00000}) +
                          t4gb_pkg::OFF_W'(x[2:1]);
    wr_next.high_nibble = x[0];
    wr_next.pixel_value = pixels[col*t4gb_pkg::PIX_W +: t4gb_pkg::PIX_W];
    wr_next.last_write  = (rest == '0);
  end

  assign emit = busy && (!out_valid || out_ready);
  assign pop  = q_valid && (!busy || (emit && (rest == '0)));

  // current row
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      mask <= '0;
    end else if (pop) begin
      busy <= 1'b1;
      mask <= q_entry.write_mask;
    end else if (emit) begin
      busy <= (rest != '0);
      mask <= rest;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      left     <= q_entry.left;
      pixels   <= q_entry.pixels;
      row_base <= q_entry.row_base;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= wr_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst) busy |-> (mask != '0))
    else $error("busy with no pending column");
  assert property (@(posedge clk) disable iff (rst)
                   emit |=> (out_valid && (out_data.last_write == $past(rest == '0))))
    else $error("last write flag out of step with the column mask");
  assert property (@(posedge clk) disable iff (rst)
                   (busy && out_valid && !out_ready) |=> $stable(mask))
    else $error("column advanced while the output was stalled");

endmodule : t4gb_back
`default_nettype wire

FILE: tb/sv/tiled_4bpp_glyph_row_blitter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tiled_4bpp_glyph_row_blitter_tb
// Self-checking testbench for the tiled 4bpp glyph row blitter.
// ----------------------------------------------------------------------------
// A short table of directed requests runs first. It covers the window
// corners, coordinate extremes, transparent and zero-width rows, wide
// glyphs and the window register extremes. Where a row's writes are
// obvious, they are typed into the table. A run of random requests then
// follows under a series of window settings. An in-bench prediction of the
// nibble writes checks every write field by field. Both sides stall in
// random bursts. The output is held off once for a long stretch, and the
// sender pauses once mid-phase until every outstanding write has been seen.
// ----------------------------------------------------------------------------
module tiled_4bpp_glyph_row_blitter_tb;

  localparam int MAX_TILES     = 32;
  localparam int LONG_HOLD     = 120;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int PHASES        = 7;
  localparam int PHASE_ROWS    = 40;
  localparam int PAUSE_PHASE   = 3;
  localparam int PAUSE_ROW     = 20;

  typedef enum logic [1:0] {
    STEP_PREDICT,
    STEP_ONE_WRITE,
    STEP_NO_WRITE,
    STEP_WINDOW
  } dir_kind_t;

  typedef struct {
    dir_kind_t                kind;
    t4gb_pkg::in_item_t       req;
    t4gb_pkg::out_item_t      write;
    logic [5:0]               w_tiles;
    logic [5:0]               h_tiles;
  } dir_step_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  t4gb_pkg::in_item_t              in_data = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  t4gb_pkg::out_item_t             out_data;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [t4gb_pkg::CFG_IDX_W-1:0]  cfg_index = t4gb_pkg::REG_WINDOW_WIDTH;
  logic [t4gb_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // shadow copies of the window registers
  logic [5:0] win_width_reg  = t4gb_pkg::WINDOW_WIDTH_RESET;
  logic [5:0] win_height_reg = t4gb_pkg::WINDOW_HEIGHT_RESET;

  t4gb_pkg::out_item_t nibble_writes_q[$];
  dir_step_t           dir_steps[$];
  t4gb_pkg::out_item_t seen_write;
  int        err_count   = 0;
  int        cycle_count = 0;
  bit        send_idle_en = 1'b1;
  bit        sink_idle_en = 1'b1;
  bit        long_hold_req = 1'b0;
  int        hold_left  = 0;
  int        stall_left = 0;

  tiled_4bpp_glyph_row_blitter #(
    .MAX_WINDOW_TILES(MAX_TILES)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // clock
  initial begin
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int tiles_used(input logic [5:0] v);
    return (v > MAX_TILES) ? MAX_TILES : int'(v);
  endfunction

  // nibble writes caused by one glyph row under the current window
  function automatic void predict_row_writes(input t4gb_pkg::in_item_t r);
    int        pitch;
    int        win_w;
    int        win_h;
    int        y;
    int        x;
    int        cols;
    int        off;
    logic [3:0] pix;
    t4gb_pkg::out_item_t w;
    t4gb_pkg::out_item_t held;
    bit        have_held;
    pitch     = tiles_used(win_width_reg);
    win_w     = pitch * 8;
    win_h     = tiles_used(win_height_reg) * 8;
    y         = int'(r.glyph_top) + int'({28'd0, r.row_index});
    cols      = (r.glyph_width > t4gb_pkg::PIXELS_PER_ROW_WORD) ?
                t4gb_pkg::PIXELS_PER_ROW_WORD : int'(r.glyph_width);
    have_held = 1'b0;
    held      = '0;
    if (y < 0 || y >= win_h) return;
    for (int c = 0; c < cols; c++) begin
      x   = int'(r.glyph_left) + c;
      pix = r.row_pixels[4*c +: 4];
      if (x < 0 || x >= win_w || pix == 4'd0) continue;
      off = ((x >> 1) & 3) + ((x >> 3) << 5) + (((y >> 3) * pitch) << 5)
          + ((y & 7) << 2);
      w.byte_offset = off[t4gb_pkg::OFF_W-1:0];
      w.high_nibble = x[0];
      w.pixel_value = pix;
      w.last_write  = 1'b0;
      if (have_held) nibble_writes_q.push_back(held);
      held      = w;
      have_held = 1'b1;
    end
    if (have_held) begin
      held.last_write = 1'b1;
      nibble_writes_q.push_back(held);
    end
  endfunction

  function automatic t4gb_pkg::in_item_t mk_row(input int l, input int t, input int ri,
                                                input int gw, input logic [31:0] px);
    t4gb_pkg::in_item_t r;
    r.glyph_left  = 16'(l);
    r.glyph_top   = 16'(t);
    r.row_index   = 4'(ri);
    r.glyph_width = 4'(gw);
    r.row_pixels  = px;
    return r;
  endfunction

  function automatic t4gb_pkg::out_item_t mk_write(input int off, input bit hn,
                                                   input int v);
    t4gb_pkg::out_item_t w;
    w.byte_offset = t4gb_pkg::OFF_W'(off);
    w.high_nibble = hn;
    w.pixel_value = 4'(v);
    w.last_write  = 1'b1;
    return w;
  endfunction

  function automatic void add_row(input dir_kind_t k, input t4gb_pkg::in_item_t r,
                                  input t4gb_pkg::out_item_t w);
    dir_step_t s;
    s.kind    = k;
    s.req     = r;
    s.write   = w;
    s.w_tiles = '0;
    s.h_tiles = '0;
    dir_steps.push_back(s);
  endfunction

  function automatic void add_window(input logic [5:0] w, input logic [5:0] h);
    dir_step_t s;
    s.kind    = STEP_WINDOW;
    s.req     = '0;
    s.write   = '0;
    s.w_tiles = w;
    s.h_tiles = h;
    dir_steps.push_back(s);
  endfunction

  // random row, mostly near the window so that clipping edges get hit
  function automatic t4gb_pkg::in_item_t rand_row();
    t4gb_pkg::in_item_t r;
    int       ww;
    int       wh;
    ww = tiles_used(win_width_reg) * 8;
    wh = tiles_used(win_height_reg) * 8;
    if ($urandom_range(0, 4) == 0) begin
      r.glyph_left = 16'($urandom());
      r.glyph_top  = 16'($urandom());
    end else begin
      r.glyph_left = 16'(int'($urandom_range(0, ww + 8)) - 8);
      r.glyph_top  = 16'(int'($urandom_range(0, wh + 16)) - 16);
    end
    r.row_index   = 4'($urandom_range(0, 15));
    r.glyph_width = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'd8;
    if ($urandom_range(0, 7) == 0) begin
      r.row_pixels = $urandom();
    end else begin
      for (int c = 0; c < t4gb_pkg::PIXELS_PER_ROW_WORD; c++)
        r.row_pixels[4*c +: 4] = ($urandom_range(0, 3) == 0) ? 4'd0
                                                            : 4'($urandom_range(1, 15));
    end
    return r;
  endfunction

  // offer one request and hold it until taken
  task automatic send_row(input t4gb_pkg::in_item_t r);
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // random sender gap before a request
  task automatic sender_gap();
    if (send_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // stop sending and let every outstanding write come out
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (nibble_writes_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write both window registers back to back
  task automatic write_window(input logic [5:0] w, input logic [5:0] h);
    cfg_valid <= 1'b1;
    cfg_index <= t4gb_pkg::REG_WINDOW_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    win_width_reg = w;
    cfg_index <= t4gb_pkg::REG_WINDOW_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    win_height_reg = h;
    cfg_valid <= 1'b0;
  endtask

  // output side: random stall bursts and one long hold-off
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = LONG_HOLD - 1;
        out_ready    <= 1'b0;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 7) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // write checker
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (nibble_writes_q.size() == 0) begin
        $error("unexpected nibble write: byte_offset %0d pixel_value %0d",
               out_data.byte_offset, out_data.pixel_value);
        err_count++;
      end else begin
        seen_write = nibble_writes_q.pop_front();
        if (out_data.byte_offset !== seen_write.byte_offset) begin
          $error("byte_offset: expected %0d, got %0d",
                 seen_write.byte_offset, out_data.byte_offset);
          err_count++;
        end
        if (out_data.high_nibble !== seen_write.high_nibble) begin
          $error("high_nibble: expected %0d, got %0d",
                 seen_write.high_nibble, out_data.high_nibble);
          err_count++;
        end
        if (out_data.pixel_value !== seen_write.pixel_value) begin
          $error("pixel_value: expected %0d, got %0d",
                 seen_write.pixel_value, out_data.pixel_value);
          err_count++;
        end
        if (out_data.last_write !== seen_write.last_write) begin
          $error("last_write: expected %0d, got %0d",
                 seen_write.last_write, out_data.last_write);
          err_count++;
        end
      end
    end
  end

  // stimulus
  initial begin
    logic [5:0] phase_w[PHASES];
    logic [5:0] phase_h[PHASES];
    t4gb_pkg::in_item_t r;

    // directed table, reset window is 30 x 20 tiles
    add_row(STEP_ONE_WRITE, mk_row(0, 0, 0, 1, 32'h1), mk_write(0, 1'b0, 1));
    add_row(STEP_ONE_WRITE, mk_row(1, 0, 0, 1, 32'hF), mk_write(0, 1'b1, 15));
    add_row(STEP_ONE_WRITE, mk_row(239, 159, 0, 1, 32'hF), mk_write(19199, 1'b1, 15));
    add_row(STEP_NO_WRITE, mk_row(0, 32767, 15, 8, 32'hFFFF_FFFF), '0);
    add_row(STEP_NO_WRITE, mk_row(0, -32768, 0, 8, 32'hFFFF_FFFF), '0);
    add_row(STEP_PREDICT, mk_row(0, -1, 1, 8, 32'h8765_4321), '0);
    add_row(STEP_NO_WRITE, mk_row(0, 0, 0, 0, 32'hFFFF_FFFF), '0);
    add_row(STEP_PREDICT, mk_row(0, 0, 0, 15, 32'hFFFF_FFFF), '0);
    add_row(STEP_NO_WRITE, mk_row(0, 0, 3, 8, 32'h0), '0);
    add_row(STEP_PREDICT, mk_row(-4, 5, 2, 8, 32'h1111_1111), '0);
    add_row(STEP_PREDICT, mk_row(236, 8, 0, 8, 32'hFEDC_BA98), '0);
    add_row(STEP_NO_WRITE, mk_row(32767, 0, 0, 8, 32'hFFFF_FFFF), '0);
    add_row(STEP_NO_WRITE, mk_row(-32768, 0, 0, 8, 32'hFFFF_FFFF), '0);
    add_row(STEP_NO_WRITE, mk_row(0, 150, 10, 8, 32'hFFFF_FFFF), '0);
    add_row(STEP_PREDICT, mk_row(16, 144, 15, 8, 32'hF0F0_F0F0), '0);
    add_row(STEP_PREDICT, mk_row(7, 100, 4, 2, 32'h0000_00FF), '0);
    // register extremes: largest legal, over-range, zero width, zero height, one tile
    add_window(6'd32, 6'd32);
    add_row(STEP_ONE_WRITE, mk_row(255, 255, 0, 1, 32'h9), mk_write(32767, 1'b1, 9));
    add_window(6'd63, 6'd63);
    add_row(STEP_ONE_WRITE, mk_row(255, 255, 0, 1, 32'h9), mk_write(32767, 1'b1, 9));
    add_window(6'd0, 6'd20);
    add_row(STEP_NO_WRITE, mk_row(0, 0, 0, 8, 32'hFFFF_FFFF), '0);
    add_window(6'd20, 6'd0);
    add_row(STEP_NO_WRITE, mk_row(0, 0, 0, 8, 32'hFFFF_FFFF), '0);
    add_window(6'd1, 6'd1);
    add_row(STEP_ONE_WRITE, mk_row(7, 7, 0, 1, 32'h3), mk_write(31, 1'b1, 3));
    add_row(STEP_PREDICT, mk_row(-2, 0, 7, 8, 32'h1234_5678), '0);

    // window settings of the random phases
    phase_w = '{6'd30, 6'd1, 6'd32, 6'd63, 6'd0, 6'd0, 6'd0};
    phase_h = '{6'd20, 6'd1, 6'd32, 6'd2, 6'd8, 6'd0, 6'd0};
    phase_w[5] = 6'($urandom_range(0, 63));
    phase_h[5] = 6'($urandom_range(0, 63));
    phase_w[6] = 6'($urandom_range(1, 32));
    phase_h[6] = 6'($urandom_range(1, 32));

    // reset
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part
    foreach (dir_steps[i]) begin
      if (dir_steps[i].kind == STEP_WINDOW) begin
        wait_idle();
        write_window(dir_steps[i].w_tiles, dir_steps[i].h_tiles);
      end else begin
        sender_gap();
        send_row(dir_steps[i].req);
        case (dir_steps[i].kind)
          STEP_PREDICT:   predict_row_writes(dir_steps[i].req);
          STEP_ONE_WRITE: nibble_writes_q.push_back(dir_steps[i].write);
          default: ;
        endcase
      end
    end

    // random phases
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      write_window(phase_w[p], phase_h[p]);
      send_idle_en = (p != 2) && (p < 5);
      sink_idle_en = (p != 2) && (p < 5);
      // long output hold-off while requests keep coming
      if (p == 1) long_hold_req = 1'b1;
      for (int i = 0; i < PHASE_ROWS; i++) begin
        if (p == PAUSE_PHASE && i == PAUSE_ROW) wait_idle();
        sender_gap();
        r = rand_row();
        send_row(r);
        predict_row_writes(r);
      end
    end

    wait_idle();
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
